// ===== hw/rtl/fsia_pkg.sv =====
// Package for the floor-semantics integer ALU: payload structs, opcodes, error codes.
// No dependencies.
package fsia_pkg;

    localparam int WORD_BITS = 64;
    localparam int CNT_BITS  = $clog2(WORD_BITS + 1);

    typedef enum logic [3:0] {
        OP_SUB = 4'd0, OP_MUL = 4'd1, OP_MOD = 4'd2, OP_FDIV = 4'd3,
        OP_POW = 4'd4, OP_NEG = 4'd5, OP_OR = 4'd6, OP_XOR = 4'd7,
        OP_AND = 4'd8, OP_SHL = 4'd9, OP_SHR = 4'd10
    } opcode_t;

    typedef enum logic [1:0] {
        ERR_OK = 2'd0, ERR_DIV0 = 2'd1, ERR_SHIFT = 2'd2, ERR_NEGEXP = 2'd3
    } err_t;

    typedef struct packed {
        logic [3:0]         opcode;
        logic signed [63:0] operand_a;
        logic signed [63:0] operand_b;
    } alu_in_t;

    typedef struct packed {
        logic signed [63:0] result;
        logic [1:0]         error_code;
    } alu_out_t;

endpackage

// ===== hw/rtl/floor_semantics_integer_alu_unit.sv =====
// Top level of the floor-semantics integer ALU.
// Depends on fsia_pkg.
//
// Usage:
//   in  channel: in_valid/in_ready carry an alu_in_t (opcode, operand_a, operand_b).
//   out channel: out_valid/out_ready carry an alu_out_t (result, error_code).
//   One transaction in gives exactly one transaction out.
// Sequencing after accept:
//   logic ops, sub, neg, shifts, errors: resolved in the decode state.
//   mul: shift-add, one multiplier bit per cycle.
//   mod / floordiv: restoring divider, one quotient bit per cycle, then a
//   floor correction step.
//   pow: each square and each conditional product reuses the same
//   shift-add multiplier. Exponent 0 is resolved in the decode state.
//   One transaction at a time: in_ready is high only when the unit is idle
//   and the output register is empty.
// Reset: rst_n (async, active low) empties the output register and returns
//   the sequencer to idle. A stalled receiver just holds the result in the
//   output register; no new input is taken until it drains.
module floor_semantics_integer_alu_unit
    import fsia_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  alu_in_t  in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output alu_out_t out_data
);

    localparam int W = WORD_BITS;

    typedef enum logic [2:0] {
        S_IDLE, S_DECODE, S_MUL, S_DIV, S_DIVFIX, S_POW, S_DONE
    } state_t;

    // pow sub-phase: multiply acc*base, then base*base
    typedef enum logic {P_ACC, P_SQR} pphase_t;

    state_t               state_reg;
    pphase_t              pphase_reg;
    logic [3:0]           op_reg;
    logic [W-1:0]         a_reg, b_reg;
    logic [W-1:0]         acc_reg;     // product accumulator / remainder
    logic [W-1:0]         mcand_reg;   // multiplicand / divisor magnitude
    logic [W-1:0]         mplier_reg;  // multiplier bits / dividend-quotient
    logic [W-1:0]         base_reg, pacc_reg, exp_reg;
    logic [CNT_BITS-1:0]  cnt_reg;
    logic                 na_reg, nb_reg;
    logic                 out_valid_reg;
    alu_out_t             out_reg;

    // shared datapath pieces
    logic [W-1:0] mul_sum;
    logic [W:0]   div_trial;
    logic [W-1:0] div_rem_sh;
    logic         bad_shift;
    logic [$clog2(W)-1:0] sh_amt;
    logic [W-1:0] q_mag, r_mag, q_s, r_s;
    logic [W-1:0] dec_result;
    err_t         dec_err;

    assign mul_sum    = mplier_reg[0] ? acc_reg + mcand_reg : acc_reg;
    assign div_rem_sh = {acc_reg[W-2:0], mplier_reg[W-1]};
    assign div_trial  = {acc_reg[W-1], div_rem_sh} - {1'b0, mcand_reg};
    assign bad_shift  = b_reg[W-1] || (b_reg >= W'(W));
    assign sh_amt     = b_reg[$clog2(W)-1:0];
    assign q_mag      = mplier_reg;
    assign r_mag      = acc_reg;
    assign q_s        = (na_reg != nb_reg) ? -q_mag : q_mag;
    assign r_s        = na_reg ? -r_mag : r_mag;

    assign in_ready  = (state_reg == S_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // single-step ops and early errors, resolved in the decode cycle
    always_comb
    begin
        dec_result = '0;
        dec_err    = ERR_OK;
        case (op_reg)
            OP_SUB: dec_result = a_reg - b_reg;
            OP_NEG: dec_result = -a_reg;
            OP_OR:  dec_result = a_reg | b_reg;
            OP_XOR: dec_result = a_reg ^ b_reg;
            OP_AND: dec_result = a_reg & b_reg;
            OP_SHL:
            begin
                if (bad_shift)
                    dec_err = ERR_SHIFT;
                else
                    dec_result = a_reg << sh_amt;
            end
            OP_SHR:
            begin
                if (bad_shift)
                    dec_err = ERR_SHIFT;
                else
                    dec_result = W'(signed'(a_reg) >>> sh_amt);
            end
            OP_MOD, OP_FDIV:
            begin
                if (b_reg == '0)
                    dec_err = ERR_DIV0;
            end
            OP_POW:
            begin
                if (b_reg[W-1])
                    dec_err = ERR_NEGEXP;
                else if (b_reg == '0)
                    dec_result = W'(1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            pphase_reg    <= P_ACC;
            cnt_reg       <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        op_reg    <= in_data.opcode;
                        a_reg     <= in_data.operand_a[W-1:0];
                        b_reg     <= in_data.operand_b[W-1:0];
                        state_reg <= S_DECODE;
                    end
                end
                S_DECODE:
                begin
                    out_reg.result     <= 64'(signed'(dec_result));
                    out_reg.error_code <= dec_err;
                    case (op_reg)
                        OP_MUL:
                        begin
                            acc_reg    <= '0;
                            mcand_reg  <= a_reg;
                            mplier_reg <= b_reg;
                            cnt_reg    <= '0;
                            state_reg  <= S_MUL;
                        end
                        OP_MOD, OP_FDIV:
                        begin
                            if (b_reg == '0)
                                state_reg <= S_DONE;
                            else
                            begin
                                na_reg     <= a_reg[W-1];
                                nb_reg     <= b_reg[W-1];
                                acc_reg    <= '0;
                                mplier_reg <= a_reg[W-1] ? -a_reg : a_reg;
                                mcand_reg  <= b_reg[W-1] ? -b_reg : b_reg;
                                cnt_reg    <= '0;
                                state_reg  <= S_DIV;
                            end
                        end
                        OP_POW:
                        begin
                            if (b_reg[W-1] || b_reg == '0)
                                state_reg <= S_DONE;
                            else
                            begin
                                base_reg   <= a_reg;
                                pacc_reg   <= {{(W-1){1'b0}}, 1'b1};
                                exp_reg    <= b_reg;
                                pphase_reg <= P_ACC;
                                acc_reg    <= '0;
                                mcand_reg  <= {{(W-1){1'b0}}, 1'b1};
                                mplier_reg <= a_reg;
                                cnt_reg    <= '0;
                                state_reg  <= S_POW;
                            end
                        end
                        default: state_reg <= S_DONE;
                    endcase
                end
                S_MUL:
                begin
                    acc_reg    <= mul_sum;
                    mcand_reg  <= mcand_reg << 1;
                    mplier_reg <= mplier_reg >> 1;
                    cnt_reg    <= cnt_reg + CNT_BITS'(1);
                    if (cnt_reg == CNT_BITS'(W - 1))
                    begin
                        out_reg.result <= 64'(signed'(mul_sum));
                        state_reg      <= S_DONE;
                    end
                end
                S_DIV:
                begin
                    if (!div_trial[W])
                    begin
                        acc_reg    <= div_trial[W-1:0];
                        mplier_reg <= {mplier_reg[W-2:0], 1'b1};
                    end
                    else
                    begin
                        acc_reg    <= div_rem_sh;
                        mplier_reg <= {mplier_reg[W-2:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + CNT_BITS'(1);
                    if (cnt_reg == CNT_BITS'(W - 1))
                        state_reg <= S_DIVFIX;
                end
                S_DIVFIX:
                begin
                    if (r_mag != '0 && na_reg != nb_reg)
                    begin
                        if (op_reg == OP_MOD)
                            out_reg.result <= 64'(signed'(r_s + b_reg));
                        else
                            out_reg.result <= 64'(signed'(q_s - W'(1)));
                    end
                    else if (op_reg == OP_MOD)
                        out_reg.result <= 64'(signed'(r_s));
                    else
                        out_reg.result <= 64'(signed'(q_s));
                    state_reg <= S_DONE;
                end
                S_POW:
                begin
                    if (pphase_reg == P_ACC && !exp_reg[0])
                    begin
                        // skip the product when the exponent bit is clear
                        pphase_reg <= P_SQR;
                        acc_reg    <= '0;
                        mcand_reg  <= base_reg;
                        mplier_reg <= base_reg;
                        cnt_reg    <= '0;
                    end
                    else if (cnt_reg == CNT_BITS'(W - 1))
                    begin
                        cnt_reg <= '0;
                        acc_reg <= '0;
                        if (pphase_reg == P_ACC)
                        begin
                            pacc_reg <= mul_sum;
                            if (exp_reg == {{(W-1){1'b0}}, 1'b1})
                            begin
                                out_reg.result <= 64'(signed'(mul_sum));
                                state_reg      <= S_DONE;
                            end
                            else
                            begin
                                pphase_reg <= P_SQR;
                                mcand_reg  <= base_reg;
                                mplier_reg <= base_reg;
                            end
                        end
                        else
                        begin
                            base_reg   <= mul_sum;
                            exp_reg    <= exp_reg >> 1;
                            pphase_reg <= P_ACC;
                            mcand_reg  <= pacc_reg;
                            mplier_reg <= mul_sum;
                        end
                    end
                    else
                    begin
                        // shift-add multiply of mcand_reg by mplier_reg
                        acc_reg    <= mul_sum;
                        mcand_reg  <= mcand_reg << 1;
                        mplier_reg <= mplier_reg >> 1;
                        cnt_reg    <= cnt_reg + CNT_BITS'(1);
                    end
                end
                S_DONE:
                begin
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // error results are always zero
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.error_code != ERR_OK |-> out_data.result == '0)
        else $error("error result not zero");
    // never accept while busy
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> !in_ready)
        else $error("ready while busy");
    // iteration counter stays in range
    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_BITS'(W))
        else $error("counter overrun");
    // finishing sets output valid
    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DONE |=> out_valid)
        else $error("done without output");

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for floor_semantics_integer_alu_unit.
// Depends on fsia_pkg and the unit RTL; no files or arguments.
`timescale 1ns / 1ps

module tb_top;
    import fsia_pkg::*;

    // Watchdog: cycles with no transaction on either side.
    // The limit covers the slowest pow plus the long receiver hold.
    localparam int WATCHDOG_LIMIT = 40000;
    localparam int RANDOM_ITEMS   = 1030;
    localparam int QUIET_TAIL     = 150;   // last items run with no idling
    localparam int LONG_HOLD      = 400;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     in_valid = 1'b0;
    logic     in_ready;
    alu_in_t  in_data = '0;
    logic     out_valid;
    logic     out_ready = 1'b0;
    alu_out_t out_data;

    always #1 clk = ~clk;

    floor_semantics_integer_alu_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // Expected results, oldest first; pushed when the input transaction is taken.
    alu_out_t pending_results[$];
    int       mismatches = 0;
    int       items_sent = 0;
    int       results_seen = 0;
    int       error_results = 0;
    bit       quiet = 1'b0;      // no idling on either side
    bit       hold_req = 1'b0;   // ask the receiver for one long stall

    localparam logic [63:0] MAX_S = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] MIN_S = 64'h8000_0000_0000_0000;
    localparam logic [63:0] ONES  = 64'hFFFF_FFFF_FFFF_FFFF;

    // ------------------------------------------------------------------
    // Predictor: floor-semantics 64-bit ALU, all overflow wraps.
    // ------------------------------------------------------------------
    function automatic alu_out_t alu_predict(input alu_in_t t);
        alu_out_t    o;
        logic [63:0] a, b, ua, ub, q, r, acc, base, e;
        logic        na, nb, bad_shift;
        a = t.operand_a;
        b = t.operand_b;
        o.result = '0;
        o.error_code = ERR_OK;
        bad_shift = b[63] || (b >= 64);
        case (t.opcode)
            OP_SUB: o.result = a - b;
            OP_MUL: o.result = a * b;
            OP_MOD, OP_FDIV:
            begin
                if (b == 0)
                    o.error_code = ERR_DIV0;
                else
                begin
                    // magnitudes, truncating divide, then pull toward -inf
                    na = a[63];
                    nb = b[63];
                    ua = na ? -a : a;
                    ub = nb ? -b : b;
                    q = ua / ub;
                    r = ua % ub;
                    if (na != nb) q = -q;
                    if (na) r = -r;
                    if (r != 0 && na != nb)
                    begin
                        r = r + b;
                        q = q - 1;
                    end
                    o.result = (t.opcode == OP_MOD) ? r : q;
                end
            end
            OP_POW:
            begin
                if (b[63])
                    o.error_code = ERR_NEGEXP;
                else
                begin
                    acc = 64'd1;
                    base = a;
                    e = b;
                    while (e != 0)
                    begin
                        if (e[0]) acc = acc * base;
                        base = base * base;
                        e = e >> 1;
                    end
                    o.result = acc;
                end
            end
            OP_NEG: o.result = -a;
            OP_OR:  o.result = a | b;
            OP_XOR: o.result = a ^ b;
            OP_AND: o.result = a & b;
            OP_SHL:
            begin
                if (bad_shift) o.error_code = ERR_SHIFT;
                else o.result = a << b[5:0];
            end
            OP_SHR:
            begin
                if (bad_shift) o.error_code = ERR_SHIFT;
                else o.result = $signed(a) >>> b[5:0];
            end
            default: ;   // unused opcodes give zero, no error
        endcase
        if (o.error_code != ERR_OK)
            o.result = '0;
        return o;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("ERROR %0t: %s got 0x%h expected 0x%h", $realtime, what, got, want);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // Output checker: every taken result against the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        alu_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
                report_mismatch("result with nothing expected", out_data.result, '0);
            else
            begin
                want = pending_results.pop_front();
                if (want.error_code != ERR_OK) error_results++;
                if (out_data.result !== want.result)
                    report_mismatch("result", out_data.result, want.result);
                if (out_data.error_code !== want.error_code)
                    report_mismatch("error_code", 64'(out_data.error_code),
                                    64'(want.error_code));
            end
        end
    end

    // Watchdog on handshake activity.
    int idle_cycles = 0;
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random ready bursts, one long hold on request.
    // ------------------------------------------------------------------
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                // long stall while the sender keeps offering; input backs up
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_req = 1'b0;
                out_ready <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 9) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
                out_ready <= 1'b1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Sender: hold valid until taken, queue the expectation at acceptance,
    // then maybe idle for a random burst.
    // ------------------------------------------------------------------
    task automatic send_item(input alu_in_t t, input alu_out_t want);
        in_valid <= 1'b1;
        in_data  <= t;
        do @(posedge clk); while (!in_ready);
        pending_results.push_back(want);
        items_sent++;
        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
    endtask

    // Directed table: a row either carries its expected result or defers
    // to the predictor.
    typedef struct {
        alu_in_t  stim;
        bit       typed;
        alu_out_t want;
    } dir_row_t;

    dir_row_t dir_tab[$];

    task automatic add_row(input logic [3:0] op, input logic [63:0] a, input logic [63:0] b,
                           input bit typed, input logic [63:0] res, input err_t err);
        dir_row_t row;
        row.stim  = '{opcode: op, operand_a: a, operand_b: b};
        row.typed = typed;
        row.want  = '{result: res, error_code: err};
        dir_tab.push_back(row);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Operand mix: full random, small signed, and the extremes.
    function automatic logic [63:0] pick_operand();
        case ($urandom_range(0, 9))
            0:       return MAX_S;
            1:       return MIN_S;
            2:       return ONES;
            3, 4:    return 64'($signed($urandom_range(0, 200)) - 100);
            default: return rand64();
        endcase
    endfunction

    function automatic alu_in_t random_item();
        alu_in_t t;
        logic [3:0] op;
        op = ($urandom_range(0, 24) == 0) ? 4'($urandom_range(11, 15))
                                          : 4'($urandom_range(0, 10));
        t.opcode = op;
        t.operand_a = pick_operand();
        t.operand_b = pick_operand();
        case (op)
            OP_MOD, OP_FDIV:
                case ($urandom_range(0, 9))
                    0: t.operand_b = '0;
                    1: t.operand_b = ONES;
                    default: ;
                endcase
            OP_POW:
            begin
                // mostly short exponents; pow time grows with exponent bit length
                if ($urandom_range(0, 59) == 0)
                    t.operand_b = rand64() >> 1;
                else if ($urandom_range(0, 9) == 0)
                    t.operand_b = rand64() | MIN_S;
                else
                    t.operand_b = 64'($urandom_range(0, 24));
            end
            OP_SHL, OP_SHR:
                if ($urandom_range(0, 7) != 0)
                    t.operand_b = 64'($urandom_range(0, 63));
            default: ;
        endcase
        return t;
    endfunction

    initial
    begin
        alu_in_t t;
        // reset once at the start
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, every operation, each special case
        add_row(OP_SUB,  MIN_S, 64'd1,  1, MAX_S, ERR_OK);
        add_row(OP_SUB,  MAX_S, ONES,   1, MIN_S, ERR_OK);
        add_row(OP_MUL,  MAX_S, MAX_S,  1, 64'd1, ERR_OK);
        add_row(OP_MUL,  rand64(), rand64(), 0, '0, ERR_OK);
        add_row(OP_MOD,  MAX_S, '0,     1, '0, ERR_DIV0);
        add_row(OP_FDIV, MIN_S, '0,     1, '0, ERR_DIV0);
        add_row(OP_FDIV, MIN_S, ONES,   1, MIN_S, ERR_OK);   // wraps
        add_row(OP_MOD,  MIN_S, ONES,   1, '0, ERR_OK);
        add_row(OP_FDIV, -64'sd7, 64'd2, 1, -64'sd4, ERR_OK); // toward -inf
        add_row(OP_MOD,  -64'sd7, 64'd2, 1, 64'd1, ERR_OK);
        add_row(OP_MOD,  64'd7, -64'sd2, 1, -64'sd1, ERR_OK); // divisor's sign
        add_row(OP_POW,  '0, '0,        1, 64'd1, ERR_OK);   // zero to the zero
        add_row(OP_POW,  64'd3, ONES,   1, '0, ERR_NEGEXP);
        add_row(OP_POW,  64'd3, 64'd40, 0, '0, ERR_OK);
        add_row(OP_NEG,  MIN_S, MAX_S,  1, MIN_S, ERR_OK);
        add_row(OP_OR,   MIN_S, MAX_S,  1, ONES, ERR_OK);
        add_row(OP_XOR,  ONES, MAX_S,   1, MIN_S, ERR_OK);
        add_row(OP_AND,  ONES, MIN_S,   1, MIN_S, ERR_OK);
        add_row(OP_SHL,  64'd1, 64'd63, 1, MIN_S, ERR_OK);
        add_row(OP_SHL,  64'd1, 64'd64, 1, '0, ERR_SHIFT);
        add_row(OP_SHR,  MIN_S, ONES,   1, '0, ERR_SHIFT);
        add_row(OP_SHR,  MIN_S, 64'd63, 1, ONES, ERR_OK);   // sign copied
        add_row(OP_SHR,  MAX_S, '0,     1, MAX_S, ERR_OK);
        add_row(4'd11,   ONES, ONES,    1, '0, ERR_OK);     // unused opcode
        add_row(4'd15,   ONES, ONES,    1, '0, ERR_OK);

        foreach (dir_tab[i])
            send_item(dir_tab[i].stim,
                      dir_tab[i].typed ? dir_tab[i].want : alu_predict(dir_tab[i].stim));

        // sender pause: let the pipeline drain completely
        in_valid <= 1'b0;
        wait (pending_results.size() == 0);
        @(posedge clk);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS / 3)
                hold_req = 1'b1;          // receiver stalls, sender keeps going
            if (n == RANDOM_ITEMS - QUIET_TAIL)
                quiet = 1'b1;
            t = random_item();
            send_item(t, alu_predict(t));
        end
        in_valid <= 1'b0;

        wait (pending_results.size() == 0);
        repeat (20) @(posedge clk);

        $display("Sent %0d transactions (%0d directed), checked %0d results, %0d with errors.",
                 items_sent, dir_tab.size(), results_seen, error_results);
        $display("Covered all eleven ops, unused opcodes, error paths and a long output stall.");
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
